/* rtl/rote_pkg.sv */
// ----------------------------------------------------------------------------
// rote_pkg
// shared types and constants of the rate of turn estimator
// ----------------------------------------------------------------------------
package rote_pkg;

  localparam int HEAD_W = 17;
  localparam int TIME_W = 32;
  localparam int RATE_W = 24;
  localparam int LIM_W  = 17;
  localparam int FL_W   = 4;
  localparam int DIV_W  = 32;

  localparam int HALF_TURN      = 18000;
  localparam int FULL_TURN      = 36000;
  localparam int MS_PER_S       = 1000;
  localparam int OUTLIER_MARGIN = 1000;
  localparam int SIMPLE_MARGIN  = 1000;
  localparam int RATE_MAX       = 8388607;

  typedef enum logic [1:0] {
    REG_FILTER_LENGTH,
    REG_MAX_RATE,
    REG_DISCARD_OUTLIERS,
    REG_RECORD_MODE
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRAP,
    OP_DIFF,
    OP_DIV_RAW,
    OP_RAW,
    OP_SIMPLE,
    OP_SHORT,
    OP_STAT_INIT,
    OP_STAT,
    OP_SQ,
    OP_VAR,
    OP_TEST,
    OP_PUSH,
    OP_DIV_MEAN,
    OP_MEAN,
    OP_FIN,
    OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WRAP,
    ST_DIFF,
    ST_DIVS,
    ST_DIVW,
    ST_RAW,
    ST_BRANCH,
    ST_STATI,
    ST_STAT,
    ST_SQ,
    ST_VAR,
    ST_TEST,
    ST_DEC,
    ST_PUSH,
    ST_STATI2,
    ST_STAT2,
    ST_MDIVS,
    ST_MDIVW,
    ST_MEAN,
    ST_FIN,
    ST_OUT
  } st_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic wrap_ok;
    logic simple_mode;
    logic short_hist;
    logic stat_done;
    logic div_done;
    logic keep;
    logic out_free;
  } stat_t;

endpackage

/* rtl/rote_ram.sv */
// ----------------------------------------------------------------------------
// rote_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rote_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rote_div.sv */
// ----------------------------------------------------------------------------
// rote_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rote_div
  import rote_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   shifted;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    shifted  = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = shifted - {1'b0, dsr_r};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/rote_dp.sv */
// ----------------------------------------------------------------------------
// rote_dp
// datapath: heading wrap, raw rate, history ring, statistics and output word
// ----------------------------------------------------------------------------
module rote_dp
  import rote_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output stat_t                    status,
  input  logic signed [HEAD_W-1:0] in_heading,
  input  logic [TIME_W-1:0]        in_sample_time,
  input  logic [FL_W-1:0]          filter_length,
  input  logic [LIM_W-1:0]         max_rate,
  input  logic                     discard_outliers,
  input  logic                     record_mode,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [RATE_W-1:0] out_rate_of_turn,
  output logic                     out_first_sample,
  output logic                     out_sample_accepted
);

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int LW   = (CW > FL_W) ? CW : FL_W;
  localparam int SUMW = RATE_W + CW;

  localparam logic signed [17:0] HALF_H = 18'(HALF_TURN);
  localparam logic signed [17:0] FULL_H = 18'(FULL_TURN);
  localparam logic [31:0]        MS32   = 32'(MS_PER_S);
  localparam logic [24:0]        OUT_M  = 25'(OUTLIER_MARGIN);
  localparam logic [24:0]        SIM_M  = 25'(SIMPLE_MARGIN);
  localparam logic [31:0]        RMAX32 = 32'(RATE_MAX);
  localparam logic [RATE_W-1:0]  RMAX   = RATE_W'(RATE_MAX);

  function automatic logic [RATE_W-1:0] clamp_lim(input logic signed [24:0] v,
                                                  input logic [LIM_W-1:0] lim);
    logic signed [24:0] l;
    logic signed [24:0] r;
    l = {8'b0, lim};
    r = v;
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end
    return r[RATE_W-1:0];
  endfunction

  // architectural state
  logic signed [15:0]       prev_h_r, prev_h_nxt;
  logic [TIME_W-1:0]        prev_t_r, prev_t_nxt;
  logic                     awaiting_r, awaiting_nxt;
  logic signed [RATE_W-1:0] cur_r, cur_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            head_r, head_nxt;

  // working registers
  logic signed [17:0]       h_r, h_nxt;
  logic [TIME_W-1:0]        t_r, t_nxt;
  logic signed [15:0]       diff_r, diff_nxt;
  logic [TIME_W-1:0]        dt_r, dt_nxt;
  logic signed [RATE_W-1:0] raw_r, raw_nxt;
  logic                     neg_r, neg_nxt;
  logic                     first_r, first_nxt;
  logic                     acc_r, acc_nxt;
  logic signed [SUMW-1:0]   sum_r, sum_nxt;
  logic [63:0]              sq_r, sq_nxt;
  logic [CW-1:0]            k_r, k_nxt;
  logic                     rd_v_r, rd_v_nxt;
  logic                     rd_k0_r, rd_k0_nxt;
  logic                     prod_v_r, prod_v_nxt;
  logic signed [RATE_W-1:0] newest_r, newest_nxt;
  logic [63:0]              nsq_r, nsq_nxt;
  logic [63:0]              var4_r, var4_nxt;
  logic [31:0]              en_r, en_nxt;
  logic                     dle_r, dle_nxt;
  logic                     pass_r, pass_nxt;
  logic [63:0]              mul_r;
  logic [31:0]              mul_a, mul_b;

  // output word
  logic                     ov_r, ov_nxt;
  logic signed [RATE_W-1:0] orate_r, orate_nxt;
  logic                     ofirst_r, ofirst_nxt;
  logic                     oacc_r, oacc_nxt;

  // ram and divider
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [RATE_W-1:0]        ram_rdata;
  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend, div_divisor, div_q;
  logic                     div_done;

  // helpers
  logic signed [17:0]       dh;
  logic [14:0]              adiff;
  logic [TIME_W-1:0]        dt_raw;
  logic [SUMW-1:0]          abs_sum;
  logic signed [RATE_W-1:0] rd_v;
  logic [RATE_W-1:0]        abs_v;
  logic signed [24:0]       raw25, cur25, sdd, rdn;
  logic [24:0]              abs_sdd, abs_raw, abs_rdn, e_val;
  logic [AW:0]              addr_sum;
  logic [LW-1:0]            fl_ext, dl_ext;
  logic [CW-1:0]            len, cnt_inc;
  logic [AW-1:0]            head_dec;
  logic [RATE_W-1:0]        mean_q;

  assign dh       = h_r - {{2{prev_h_r[15]}}, prev_h_r};
  assign adiff    = diff_r[15] ? 15'(-diff_r) : diff_r[14:0];
  assign dt_raw   = t_r - prev_t_r;
  assign abs_sum  = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
  assign rd_v     = ram_rdata;
  assign abs_v    = rd_v[RATE_W-1] ? RATE_W'(-rd_v) : RATE_W'(rd_v);
  assign raw25    = {raw_r[RATE_W-1], raw_r};
  assign cur25    = {cur_r[RATE_W-1], cur_r};
  assign sdd      = raw25 - cur25;
  assign abs_sdd  = sdd[24] ? 25'(-sdd) : 25'(sdd);
  assign abs_raw  = raw25[24] ? 25'(-raw25) : 25'(raw25);
  assign rdn      = raw25 - {newest_r[RATE_W-1], newest_r};
  assign abs_rdn  = rdn[24] ? 25'(-rdn) : 25'(rdn);
  assign e_val    = abs_rdn - OUT_M;
  assign addr_sum = {1'b0, head_r} + (AW+1)'(k_r);
  assign ram_raddr = (addr_sum >= (AW+1)'(HISTORY_DEPTH))
                     ? AW'(addr_sum - (AW+1)'(HISTORY_DEPTH)) : addr_sum[AW-1:0];
  assign fl_ext   = LW'(filter_length);
  assign dl_ext   = LW'(HISTORY_DEPTH);
  assign len      = (fl_ext > dl_ext) ? CW'(dl_ext) : CW'(fl_ext);
  assign head_dec = (head_r == '0) ? AW'(HISTORY_DEPTH - 1) : head_r - 1'b1;
  assign cnt_inc  = (cnt_r == CW'(HISTORY_DEPTH)) ? cnt_r : cnt_r + 1'b1;
  assign mean_q   = neg_r ? RATE_W'(-div_q[RATE_W-1:0]) : div_q[RATE_W-1:0];

  always_comb begin
    prev_h_nxt   = prev_h_r;
    prev_t_nxt   = prev_t_r;
    awaiting_nxt = awaiting_r;
    cur_nxt      = cur_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    h_nxt        = h_r;
    t_nxt        = t_r;
    diff_nxt     = diff_r;
    dt_nxt       = dt_r;
    raw_nxt      = raw_r;
    neg_nxt      = neg_r;
    first_nxt    = first_r;
    acc_nxt      = acc_r;
    sum_nxt      = sum_r;
    sq_nxt       = sq_r;
    k_nxt        = k_r;
    rd_v_nxt     = 1'b0;
    rd_k0_nxt    = 1'b0;
    prod_v_nxt   = 1'b0;
    newest_nxt   = newest_r;
    nsq_nxt      = nsq_r;
    var4_nxt     = var4_r;
    en_nxt       = en_r;
    dle_nxt      = dle_r;
    pass_nxt     = pass_r;
    mul_a        = '0;
    mul_b        = '0;
    ram_we       = 1'b0;
    ram_waddr    = head_dec;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    ov_nxt       = out_ready ? 1'b0 : ov_r;
    orate_nxt    = orate_r;
    ofirst_nxt   = ofirst_r;
    oacc_nxt     = oacc_r;

    case (cmd.op)
      OP_LOAD: begin
        h_nxt     = {in_heading[HEAD_W-1], in_heading};
        t_nxt     = in_sample_time;
        first_nxt = awaiting_r;
        acc_nxt   = 1'b0;
      end
      OP_WRAP: begin
        if (h_r >= HALF_H) begin
          h_nxt = h_r - FULL_H;
        end else if (h_r < -HALF_H) begin
          h_nxt = h_r + FULL_H;
        end
      end
      OP_DIFF: begin
        if (dh >= HALF_H) begin
          diff_nxt = 16'(dh - FULL_H);
        end else if (dh < -HALF_H) begin
          diff_nxt = 16'(dh + FULL_H);
        end else begin
          diff_nxt = dh[15:0];
        end
        dt_nxt = (dt_raw == '0) ? TIME_W'(1) : dt_raw;
      end
      OP_DIV_RAW: begin
        div_start    = 1'b1;
        div_dividend = 32'(adiff) * MS32;
        div_divisor  = dt_r;
        neg_nxt      = diff_r[15];
      end
      OP_RAW: begin
        if (!neg_r) begin
          raw_nxt = (div_q > RMAX32) ? RMAX : div_q[RATE_W-1:0];
        end else begin
          raw_nxt = (div_q > RMAX32 + 32'd1) ? ~RMAX : RATE_W'(-div_q[RATE_W-1:0]);
        end
      end
      OP_SIMPLE: begin
        if (abs_sdd < SIM_M || !discard_outliers) begin
          cur_nxt = clamp_lim(raw25, max_rate);
        end else begin
          cur_nxt = clamp_lim(cur25, max_rate);
        end
      end
      OP_SHORT: begin
        if (abs_raw < {8'b0, max_rate} || record_mode) begin
          ram_we   = 1'b1;
          head_nxt = head_dec;
          cnt_nxt  = (cnt_inc > len) ? len : cnt_inc;
          cur_nxt  = raw_r;
          acc_nxt  = 1'b1;
        end else begin
          cur_nxt = clamp_lim(raw25, max_rate);
        end
      end
      OP_STAT_INIT: begin
        k_nxt   = '0;
        sum_nxt = '0;
        sq_nxt  = '0;
      end
      OP_STAT: begin
        if (k_r < cnt_r) begin
          rd_v_nxt  = 1'b1;
          rd_k0_nxt = (k_r == '0);
          k_nxt     = k_r + 1'b1;
        end
        if (rd_v_r) begin
          sum_nxt    = sum_r + {{(SUMW-RATE_W){rd_v[RATE_W-1]}}, rd_v};
          mul_a      = 32'(abs_v);
          mul_b      = 32'(abs_v);
          prod_v_nxt = 1'b1;
          if (rd_k0_r) begin
            newest_nxt = rd_v;
          end
        end
        if (prod_v_r) begin
          sq_nxt = sq_r + mul_r;
        end
      end
      OP_SQ: begin
        mul_a   = 32'(abs_sum);
        mul_b   = 32'(abs_sum);
        nsq_nxt = 64'(cnt_r) * sq_r;
        dle_nxt = (abs_rdn <= OUT_M);
        en_nxt  = 32'(e_val) * 32'(cnt_r);
      end
      OP_VAR: begin
        var4_nxt = (nsq_r - mul_r) << 2;
        mul_a    = en_r;
        mul_b    = en_r;
      end
      OP_TEST: begin
        pass_nxt = dle_r || (mul_r <= var4_r);
      end
      OP_PUSH: begin
        ram_we   = 1'b1;
        head_nxt = head_dec;
        cnt_nxt  = (cnt_inc > len) ? len : cnt_inc;
        acc_nxt  = 1'b1;
      end
      OP_DIV_MEAN: begin
        div_start    = 1'b1;
        div_dividend = 32'(abs_sum);
        div_divisor  = 32'(cnt_r);
        neg_nxt      = sum_r[SUMW-1];
      end
      OP_MEAN: begin
        cur_nxt = mean_q;
      end
      OP_FIN: begin
        prev_h_nxt   = h_r[15:0];
        prev_t_nxt   = t_r;
        awaiting_nxt = 1'b0;
      end
      OP_EMIT: begin
        ov_nxt     = 1'b1;
        orate_nxt  = cur_r;
        ofirst_nxt = first_r;
        oacc_nxt   = acc_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_h_r   <= '0;
      prev_t_r   <= '0;
      awaiting_r <= 1'b1;
      cur_r      <= '0;
      cnt_r      <= '0;
      head_r     <= '0;
      rd_v_r     <= 1'b0;
      rd_k0_r    <= 1'b0;
      prod_v_r   <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      prev_h_r   <= prev_h_nxt;
      prev_t_r   <= prev_t_nxt;
      awaiting_r <= awaiting_nxt;
      cur_r      <= cur_nxt;
      cnt_r      <= cnt_nxt;
      head_r     <= head_nxt;
      rd_v_r     <= rd_v_nxt;
      rd_k0_r    <= rd_k0_nxt;
      prod_v_r   <= prod_v_nxt;
      ov_r       <= ov_nxt;
    end
    h_r      <= h_nxt;
    t_r      <= t_nxt;
    diff_r   <= diff_nxt;
    dt_r     <= dt_nxt;
    raw_r    <= raw_nxt;
    neg_r    <= neg_nxt;
    first_r  <= first_nxt;
    acc_r    <= acc_nxt;
    sum_r    <= sum_nxt;
    sq_r     <= sq_nxt;
    k_r      <= k_nxt;
    newest_r <= newest_nxt;
    nsq_r    <= nsq_nxt;
    var4_r   <= var4_nxt;
    en_r     <= en_nxt;
    dle_r    <= dle_nxt;
    pass_r   <= pass_nxt;
    mul_r    <= mul_a * mul_b;
    orate_r  <= orate_nxt;
    ofirst_r <= ofirst_nxt;
    oacc_r   <= oacc_nxt;
  end

  rote_ram #(
    .WIDTH(RATE_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(raw_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rote_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    status.first       = first_r;
    status.wrap_ok     = (h_r >= -HALF_H) && (h_r < HALF_H);
    status.simple_mode = (filter_length <= FL_W'(1));
    status.short_hist  = (cnt_r < CW'(2));
    status.stat_done   = (k_r == cnt_r) && !rd_v_r && !prod_v_r;
    status.div_done    = div_done;
    status.keep        = pass_r || !discard_outliers;
    status.out_free    = !ov_r || out_ready;
  end

  assign out_valid           = ov_r;
  assign out_rate_of_turn    = orate_r;
  assign out_first_sample    = ofirst_r;
  assign out_sample_accepted = oacc_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HISTORY_DEPTH))
    else $error("history count above depth");
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(HISTORY_DEPTH - 1))
    else $error("history head out of range");
  a_first_no_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !(ofirst_r && oacc_r))
    else $error("first word flagged as stored");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUSH) |=> (cnt_r >= CW'(2)))
    else $error("push left fewer than two entries");
`endif

endmodule

/* rtl/rote_ctrl.sv */
// ----------------------------------------------------------------------------
// rote_ctrl
// sequencer that steps the datapath through one heading sample
// ----------------------------------------------------------------------------
module rote_ctrl
  import rote_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t status,
  output cmd_t  cmd
);

  st_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_WRAP;
      ST_WRAP:   if (status.wrap_ok) state_nxt = status.first ? ST_FIN : ST_DIFF;
      ST_DIFF:   state_nxt = ST_DIVS;
      ST_DIVS:   state_nxt = ST_DIVW;
      ST_DIVW:   if (status.div_done) state_nxt = ST_RAW;
      ST_RAW:    state_nxt = ST_BRANCH;
      ST_BRANCH: begin
        if (status.simple_mode || status.short_hist) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_STATI;
        end
      end
      ST_STATI:  state_nxt = ST_STAT;
      ST_STAT:   if (status.stat_done) state_nxt = ST_SQ;
      ST_SQ:     state_nxt = ST_VAR;
      ST_VAR:    state_nxt = ST_TEST;
      ST_TEST:   state_nxt = ST_DEC;
      ST_DEC:    state_nxt = status.keep ? ST_PUSH : ST_MDIVS;
      ST_PUSH:   state_nxt = ST_STATI2;
      ST_STATI2: state_nxt = ST_STAT2;
      ST_STAT2:  if (status.stat_done) state_nxt = ST_MDIVS;
      ST_MDIVS:  state_nxt = ST_MDIVW;
      ST_MDIVW:  if (status.div_done) state_nxt = ST_MEAN;
      ST_MEAN:   state_nxt = ST_FIN;
      ST_FIN:    state_nxt = ST_OUT;
      ST_OUT:    if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_WRAP:   cmd.op = OP_WRAP;
      ST_DIFF:   cmd.op = OP_DIFF;
      ST_DIVS:   cmd.op = OP_DIV_RAW;
      ST_RAW:    cmd.op = OP_RAW;
      ST_BRANCH: begin
        if (status.simple_mode) begin
          cmd.op = OP_SIMPLE;
        end else if (status.short_hist) begin
          cmd.op = OP_SHORT;
        end
      end
      ST_STATI, ST_STATI2: cmd.op = OP_STAT_INIT;
      ST_STAT, ST_STAT2:   cmd.op = OP_STAT;
      ST_SQ:     cmd.op = OP_SQ;
      ST_VAR:    cmd.op = OP_VAR;
      ST_TEST:   cmd.op = OP_TEST;
      ST_PUSH:   cmd.op = OP_PUSH;
      ST_MDIVS:  cmd.op = OP_DIV_MEAN;
      ST_MEAN:   cmd.op = OP_MEAN;
      ST_FIN:    cmd.op = OP_FIN;
      ST_OUT:    if (status.out_free) cmd.op = OP_EMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/rate_of_turn_estimator.sv */
// ----------------------------------------------------------------------------
// rate_of_turn_estimator
// turn rate from timestamped headings, averaged over a history ring
// ----------------------------------------------------------------------------
// sequence: a first sample is only wrapped and kept as the previous heading,
//   simple mode and short history stop after the raw rate, two or more history
//   entries add the statistics; a heading outside +-180 degrees is wrapped a
//   step at a time; the 32-bit divider serves the raw rate and, on the statistics path, the mean
// throughput: one word at a time, the next is taken once the result sits in
//   the output register
// reset: synchronous, active low; state and configuration registers return to their defaults, the
//   history ring needs no clearing since only counted entries are read
module rate_of_turn_estimator
  import rote_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input word channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [HEAD_W-1:0] in_heading,
  input  logic [TIME_W-1:0]        in_sample_time,
  // result word channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [RATE_W-1:0] out_rate_of_turn,
  output logic                     out_first_sample,
  output logic                     out_sample_accepted,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // configuration registers
  logic [FL_W-1:0]  filter_length_r, filter_length_nxt;
  logic [LIM_W-1:0] max_rate_r, max_rate_nxt;
  logic             discard_r, discard_nxt;
  logic             record_r, record_nxt;
  logic             wr_en;
  reg_idx_t         reg_idx;

  cmd_t  cmd;
  stat_t status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  // register write decode, word address in the upper address bits
  always_comb begin
    filter_length_nxt = filter_length_r;
    max_rate_nxt      = max_rate_r;
    discard_nxt       = discard_r;
    record_nxt        = record_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FILTER_LENGTH:    filter_length_nxt = pwdata[FL_W-1:0];
        REG_MAX_RATE:         max_rate_nxt      = pwdata[LIM_W-1:0];
        REG_DISCARD_OUTLIERS: discard_nxt       = pwdata[0];
        REG_RECORD_MODE:      record_nxt        = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_FILTER_LENGTH:    prdata = 32'(filter_length_r);
      REG_MAX_RATE:         prdata = 32'(max_rate_r);
      REG_DISCARD_OUTLIERS: prdata = 32'(discard_r);
      REG_RECORD_MODE:      prdata = 32'(record_r);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_length_r <= FL_W'(4);
      max_rate_r      <= LIM_W'(6000);
      discard_r       <= 1'b0;
      record_r        <= 1'b0;
    end else begin
      filter_length_r <= filter_length_nxt;
      max_rate_r      <= max_rate_nxt;
      discard_r       <= discard_nxt;
      record_r        <= record_nxt;
    end
  end

  // sequencer
  rote_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // arithmetic, history ring and output register
  rote_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_heading         (in_heading),
    .in_sample_time     (in_sample_time),
    .filter_length      (filter_length_r),
    .max_rate           (max_rate_r),
    .discard_outliers   (discard_r),
    .record_mode        (record_r),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_rate_of_turn   (out_rate_of_turn),
    .out_first_sample   (out_first_sample),
    .out_sample_accepted(out_sample_accepted)
  );

endmodule
